// ----- hw/rtl/daub4_pkg.sv -----
// shared types, constants and the rounding function for the d4 wavelet level
// used by daub4_agen, daub4_mac and daub4_periodic_wavelet_level; no dependencies
package daub4_pkg;

    localparam int LEN_W   = 7;
    localparam int SAMP_W  = 18;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = SAMP_W + COEF_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_1       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_2       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_3       = 3'd5;

    localparam logic [LEN_W-1:0]  RST_BLOCK_LENGTH = 7'd64;
    localparam logic [COEF_W-1:0] RST_COEF_0 = 16'sd15826;
    localparam logic [COEF_W-1:0] RST_COEF_1 = 16'sd27411;
    localparam logic [COEF_W-1:0] RST_COEF_2 = 16'sd7345;
    localparam logic [COEF_W-1:0] RST_COEF_3 = -16'sd4240;

    // filter tap selectors
    localparam logic [1:0] TAP_C0 = 2'd0;
    localparam logic [1:0] TAP_C1 = 2'd1;
    localparam logic [1:0] TAP_C2 = 2'd2;
    localparam logic [1:0] TAP_C3 = 2'd3;

    localparam logic [1:0] TAP_FIRST = 2'd0;
    localparam logic [1:0] TAP_FINAL = 2'd3;

    typedef logic [3:0][COEF_W-1:0] coef_set_t;

    typedef struct packed {
        logic [1:0] coef_sel;
        logic       negate;
        logic       first_tap;
        logic       final_tap;
        logic       block_end;
    } tap_t;

    localparam logic signed [ACC_W:0] ROUND_HALF = 37'sd16384;
    localparam logic signed [ACC_W-15:0] SAT_MAX = 22'sd131071;
    localparam logic signed [ACC_W-15:0] SAT_MIN = -22'sd131072;

    // round to nearest with ties up, then saturate to the sample width
    function automatic logic [SAMP_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]    sum;
        logic signed [ACC_W-15:0] q;
        logic [SAMP_W-1:0]        res;
        sum = {acc[ACC_W-1], acc} + ROUND_HALF;
        q   = sum[ACC_W:15];
        if (q > SAT_MAX)
            res = SAT_MAX[SAMP_W-1:0];
        else if (q < SAT_MIN)
            res = SAT_MIN[SAMP_W-1:0];
        else
            res = q[SAMP_W-1:0];
        return res;
    endfunction

endpackage

// ----- hw/rtl/daub4_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module daub4_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/daub4_agen.sv -----
// buffer address and filter tap selection for one tap of one result
// depends on daub4_pkg
module daub4_agen #(
    parameter int MAX_LENGTH = 64,
    localparam int AW = $clog2(MAX_LENGTH)
) (
    input  logic [daub4_pkg::LEN_W-1:0] item,
    input  logic [1:0]                  tap,
    input  logic [daub4_pkg::LEN_W-1:0] length,
    input  logic                        inverse,
    output logic [AW-1:0]               addr,
    output daub4_pkg::tap_t             tap_info
);

    localparam int LW = daub4_pkg::LEN_W;

    logic [LW-1:0] half;
    logic          detail;
    logic [LW-1:0] fwd_i;
    logic [LW-1:0] fwd_sum;
    logic [LW-1:0] fwd_addr;
    logic [LW-1:0] inv_i;
    logic [LW-1:0] inv_p;
    logic [LW-1:0] inv_sel;
    logic [LW-1:0] inv_addr;
    logic [1:0]    coef_sel;
    logic          negate;

    always_comb
    begin
        half    = length >> 1;
        // forward: smooth outputs first, then detail outputs
        detail  = (item >= half);
        fwd_i   = detail ? (item - half) : item;
        fwd_sum = (fwd_i << 1) + LW'(tap);
        fwd_addr = (fwd_sum >= length) ? (fwd_sum - length) : fwd_sum;

        // inverse: taps read a[p], d[p], a[i], d[i] with periodic wrap of p
        inv_i   = item >> 1;
        inv_p   = (inv_i == '0) ? (half - LW'(1)) : (inv_i - LW'(1));
        inv_sel = tap[1] ? inv_i : inv_p;
        inv_addr = tap[0] ? (inv_sel + half) : inv_sel;

        coef_sel = daub4_pkg::TAP_C0;
        negate   = 1'b0;
        if (!inverse)
        begin
            coef_sel = detail ? ~tap : tap;
            negate   = detail & tap[0];
        end
        else if (!item[0])
        begin
            case (tap)
                2'd0:    coef_sel = daub4_pkg::TAP_C2;
                2'd1:    coef_sel = daub4_pkg::TAP_C1;
                2'd2:    coef_sel = daub4_pkg::TAP_C0;
                default: coef_sel = daub4_pkg::TAP_C3;
            endcase
        end
        else
        begin
            case (tap)
                2'd0:    coef_sel = daub4_pkg::TAP_C3;
                2'd1:    coef_sel = daub4_pkg::TAP_C0;
                2'd2:    coef_sel = daub4_pkg::TAP_C1;
                default: coef_sel = daub4_pkg::TAP_C2;
            endcase
            negate = tap[0];
        end

        addr = inverse ? inv_addr[AW-1:0] : fwd_addr[AW-1:0];
        tap_info.coef_sel  = coef_sel;
        tap_info.negate    = negate;
        tap_info.first_tap = (tap == daub4_pkg::TAP_FIRST);
        tap_info.final_tap = (tap == daub4_pkg::TAP_FINAL);
        tap_info.block_end = (item == (length - LW'(1)));
    end

endmodule

// ----- hw/rtl/daub4_mac.sv -----
// multiply-accumulate pipeline: buffer data times tap, four-term sum, round and saturate
// depends on daub4_pkg
module daub4_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               tap_valid,
    input  daub4_pkg::tap_t                    tap_info,
    input  daub4_pkg::coef_set_t               coefs,
    input  logic signed [daub4_pkg::SAMP_W-1:0] rd_data,
    output logic                               fin_valid,
    output logic [daub4_pkg::SAMP_W-1:0]       fin_value,
    output logic                               fin_last
);

    localparam int PW = daub4_pkg::PROD_W;
    localparam int AW = daub4_pkg::ACC_W;

    logic                   s1_valid_reg;
    daub4_pkg::tap_t        s1_tap_reg;
    logic                   s2_valid_reg;
    daub4_pkg::tap_t        s2_tap_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   prod_next;
    logic signed [daub4_pkg::COEF_W-1:0] coef_val;
    logic signed [AW-1:0]   term;
    logic signed [AW-1:0]   acc_reg;
    logic signed [AW-1:0]   acc_next;
    logic                   acc_done_reg;
    logic                   acc_last_reg;
    logic                   fin_valid_reg;
    logic [daub4_pkg::SAMP_W-1:0] fin_value_reg;
    logic                   fin_last_reg;

    always_comb
    begin
        coef_val  = $signed(coefs[s1_tap_reg.coef_sel]);
        prod_next = rd_data * coef_val;
        term      = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
        if (s2_tap_reg.negate)
            term = -term;
        acc_next  = s2_tap_reg.first_tap ? term : (acc_reg + term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            acc_done_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= tap_valid;
            s2_valid_reg  <= s1_valid_reg;
            acc_done_reg  <= s2_valid_reg & s2_tap_reg.final_tap;
            fin_valid_reg <= acc_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tap_reg <= tap_info;
        s2_tap_reg <= s1_tap_reg;
        prod_reg   <= prod_next;
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        acc_last_reg  <= s2_tap_reg.block_end;
        fin_value_reg <= daub4_pkg::finish(acc_reg);
        fin_last_reg  <= acc_last_reg;
    end

    assign fin_valid = fin_valid_reg;
    assign fin_value = fin_value_reg;
    assign fin_last  = fin_last_reg;

endmodule

// ----- hw/rtl/daub4_periodic_wavelet_level.sv -----
// top level of the one-level d4 wavelet transform with periodic wrap
// depends on daub4_pkg, daub4_ram, daub4_agen and daub4_mac
//
// Samples of a block are taken one per cycle into a buffer ram until the
// effective block length (block_length clamped to 4..MAX_LENGTH, low bit cleared)
// is reached; input then stalls while the block is emitted. Each result is a
// four-term sum that needs four reads from the single buffer read port, so the
// emit phase issues the reads of one result before it starts the next, and
// starts a result only while the output and hold slots can take it. The data
// of each read passes the buffer read register, the product register, the
// accumulator, the rounding register and then the output register or its hold
// slot. Loading of the next block may start while the final results drain.
// Forward mode gives the smooth half then the detail half; inverse mode reads
// smooth then detail and gives the interleaved samples. last marks the final
// result of a block. Configuration is written through a port that is always
// ready and should only change while the block is idle.
module daub4_periodic_wavelet_level #(
    parameter int MAX_LENGTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [daub4_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [daub4_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [daub4_pkg::SAMP_W-1:0]  sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [daub4_pkg::SAMP_W-1:0]  value,
    output logic                                 last
);

    localparam int LW = daub4_pkg::LEN_W;
    localparam int SW = daub4_pkg::SAMP_W;
    localparam int AW = $clog2(MAX_LENGTH);

    typedef enum logic {ST_LOAD, ST_EMIT} state_t;

    state_t          state_reg, state_next;
    logic [LW-1:0]   block_length_reg;
    logic            inverse_mode_reg;
    daub4_pkg::coef_set_t coef_reg;
    logic [LW-1:0]   fill_reg, fill_next;
    logic [LW-1:0]   item_reg, item_next;
    logic [1:0]      tap_reg, tap_next;
    logic [1:0]      inflight_reg, inflight_next;
    logic            out_valid_reg, out_valid_next;
    logic            hold_valid_reg, hold_valid_next;
    logic [SW-1:0]   out_value_reg;
    logic            out_last_reg;
    logic [SW-1:0]   hold_value_reg;
    logic            hold_last_reg;

    logic [LW-1:0]   length;
    logic [LW-1:0]   fill_plus;
    logic            in_xfer;
    logic            out_xfer;
    logic            out_free;
    logic            can_start;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [SW-1:0]   rd_data;
    daub4_pkg::tap_t tap_info;
    logic            fin_valid;
    logic [SW-1:0]   fin_value;
    logic            fin_last;

    // effective block length
    always_comb
    begin
        if (block_length_reg < LW'(4))
            length = LW'(4);
        else if (block_length_reg > LW'(MAX_LENGTH))
            length = LW'(MAX_LENGTH);
        else
            length = block_length_reg;
        length[0] = 1'b0;
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= daub4_pkg::RST_BLOCK_LENGTH;
            inverse_mode_reg <= 1'b0;
            coef_reg[0]      <= daub4_pkg::RST_COEF_0;
            coef_reg[1]      <= daub4_pkg::RST_COEF_1;
            coef_reg[2]      <= daub4_pkg::RST_COEF_2;
            coef_reg[3]      <= daub4_pkg::RST_COEF_3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                daub4_pkg::REG_BLOCK_LENGTH: block_length_reg <= cfg_data[LW-1:0];
                daub4_pkg::REG_INVERSE_MODE: inverse_mode_reg <= cfg_data[0];
                daub4_pkg::REG_COEF_0:       coef_reg[0] <= cfg_data;
                daub4_pkg::REG_COEF_1:       coef_reg[1] <= cfg_data;
                daub4_pkg::REG_COEF_2:       coef_reg[2] <= cfg_data;
                daub4_pkg::REG_COEF_3:       coef_reg[3] <= cfg_data;
                default:                     ;
            endcase
        end
    end

    daub4_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_LENGTH)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (in_xfer),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    daub4_agen #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_agen (
        .item     (item_reg),
        .tap      (tap_reg),
        .length   (length),
        .inverse  (inverse_mode_reg),
        .addr     (rd_addr),
        .tap_info (tap_info)
    );

    daub4_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_valid (rd_en),
        .tap_info  (tap_info),
        .coefs     (coef_reg),
        .rd_data   (rd_data),
        .fin_valid (fin_valid),
        .fin_value (fin_value),
        .fin_last  (fin_last)
    );

    assign in_stall = (state_reg != ST_LOAD);
    assign in_xfer  = in_valid & ~in_stall;
    assign out_xfer = out_valid_reg & ~out_stall;
    assign out_free = ~out_valid_reg | out_xfer;
    assign fill_plus = fill_reg + LW'(1);
    // a new result may start only if the output and hold slots can take it
    assign can_start = ((inflight_reg - {1'b0, out_xfer}) < 2'd2);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        item_next       = item_reg;
        tap_next        = tap_reg;
        rd_en           = 1'b0;
        out_valid_next  = out_valid_reg;
        hold_valid_next = hold_valid_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (fill_plus >= length)
                    begin
                        fill_next  = '0;
                        item_next  = '0;
                        tap_next   = daub4_pkg::TAP_FIRST;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        fill_next = fill_plus;
                    end
                end
            end
            ST_EMIT:
            begin
                if (tap_reg != daub4_pkg::TAP_FIRST || can_start)
                begin
                    rd_en    = 1'b1;
                    tap_next = tap_reg + 2'd1;
                    if (tap_reg == daub4_pkg::TAP_FINAL)
                    begin
                        item_next = item_reg + LW'(1);
                        if (item_reg == (length - LW'(1)))
                        begin
                            item_next  = '0;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        inflight_next = inflight_reg
                      + {1'b0, rd_en && (tap_reg == daub4_pkg::TAP_FIRST)}
                      - {1'b0, out_xfer};

        // output register with one hold slot behind it
        if (out_free)
        begin
            out_valid_next  = hold_valid_reg | fin_valid;
            hold_valid_next = hold_valid_reg & fin_valid;
        end
        else if (fin_valid)
        begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            fill_reg       <= '0;
            item_reg       <= '0;
            tap_reg        <= daub4_pkg::TAP_FIRST;
            inflight_reg   <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            item_reg       <= item_next;
            tap_reg        <= tap_next;
            inflight_reg   <= inflight_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (hold_valid_reg)
            begin
                out_value_reg  <= hold_value_reg;
                out_last_reg   <= hold_last_reg;
                hold_value_reg <= fin_value;
                hold_last_reg  <= fin_last;
            end
            else
            begin
                out_value_reg <= fin_value;
                out_last_reg  <= fin_last;
            end
        end
        else if (fin_valid)
        begin
            hold_value_reg <= fin_value;
            hold_last_reg  <= fin_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign last      = out_last_reg;

endmodule
